// File: rtl/ptw_pkg.sv
// Package for the four-level page table walker.
// Holds field widths, operation and result codes, and the command type
// passed from the walk front end to the address back end. No dependencies.
package ptw_pkg;

  // Physical address bits kept in table bases (range 32..52)
  localparam int PHYS_BITS = 36;

  // Field widths
  localparam int OP_W    = 1;
  localparam int ROOT_W  = 36;
  localparam int LA_W    = 48;
  localparam int ENTRY_W = 64;
  localparam int KIND_W  = 2;
  localparam int ADDR_W  = 52;
  localparam int OFF_W   = 30;
  localparam int IDX_W   = 9;
  localparam int PAGE_SHIFT = 12;

  // Entry bit positions
  localparam int PRESENT_POS = 0;
  localparam int LARGE_POS   = 7;
  localparam int GIB_SHIFT   = 30;

  // Linear address index positions per level
  localparam int IDX1_POS = 39;
  localparam int IDX2_POS = 30;
  localparam int IDX3_POS = 21;
  localparam int IDX4_POS = 12;
  localparam int MIB_OFF_W = 21;

  // Input operation codes
  localparam logic [OP_W-1:0] OP_TRANSLATE = 1'b0;
  localparam logic [OP_W-1:0] OP_ENTRY     = 1'b1;

  // Result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_READ  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_FAULT = 2'd2
  } kind_e;

  // One result to form: address = base + offset
  typedef struct packed {
    kind_e              kind;
    logic [ADDR_W-1:0]  base;
    logic [OFF_W-1:0]   offset;
  } cmd_t;

  // Command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

endpackage

// File: rtl/ptw_if.sv
// Valid/ready channel interfaces for the page table walker.
// Depends on ptw_pkg for the payload widths.
interface ptw_req_if import ptw_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [ROOT_W-1:0]   table_root;
  logic [LA_W-1:0]     linear_address;
  logic [ENTRY_W-1:0]  entry_word;

  modport source (output valid, op, table_root, linear_address, entry_word, input ready);
  modport sink   (input valid, op, table_root, linear_address, entry_word, output ready);
endinterface

interface ptw_rsp_if import ptw_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [ADDR_W-1:0]  address;

  modport source (output valid, kind, address, input ready);
  modport sink   (input valid, kind, address, output ready);
endinterface

// File: rtl/ptw_front.sv
// Walk front end: accepts transactions, tracks the walk level and the held
// linear address, and turns each productive transaction into a command.
// Depends on ptw_pkg.
module ptw_front import ptw_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic [OP_W-1:0]    op_i,
  input  logic [ROOT_W-1:0]  table_root_i,
  input  logic [LA_W-1:0]    linear_address_i,
  input  logic [ENTRY_W-1:0] entry_word_i,
  output logic               push_o,
  output cmd_t               cmd_o,
  input  logic               q_ready_i
);

  localparam logic [2:0] LVL_IDLE = 3'd0;
  localparam logic [2:0] LVL_1    = 3'd1;
  localparam logic [2:0] LVL_2    = 3'd2;
  localparam logic [2:0] LVL_3    = 3'd3;
  localparam logic [2:0] LVL_4    = 3'd4;

  logic [2:0]        level_q, level_d;
  logic [LA_W-1:0]   la_q, la_d;
  logic              accept;
  logic              emit;
  logic              present;
  logic              large_page;
  logic [ADDR_W-1:0] ent_base;
  logic [ADDR_W-1:0] gib_base;
  logic [ADDR_W-1:0] root_base;
  logic [OFF_W-1:0]  idx_off2, idx_off3, idx_off4, root_off;

  assign ready_o    = q_ready_i;
  assign accept     = valid_i && ready_o;
  assign present    = entry_word_i[PRESENT_POS];
  assign large_page = entry_word_i[LARGE_POS];

  // Form candidate bases and index offsets
  assign ent_base  = ADDR_W'(entry_word_i[PHYS_BITS-1:PAGE_SHIFT]) << PAGE_SHIFT;
  assign gib_base  = {entry_word_i[ADDR_W-1:GIB_SHIFT], {GIB_SHIFT{1'b0}}};
  assign root_base = ADDR_W'({table_root_i[ROOT_W-1:4], 4'b0});
  assign root_off  = OFF_W'({linear_address_i[IDX1_POS +: IDX_W], 3'b0});
  assign idx_off2  = OFF_W'({la_q[IDX2_POS +: IDX_W], 3'b0});
  assign idx_off3  = OFF_W'({la_q[IDX3_POS +: IDX_W], 3'b0});
  assign idx_off4  = OFF_W'({la_q[IDX4_POS +: IDX_W], 3'b0});

  // Classify the transaction and pick the next level
  always_comb begin
    level_d     = level_q;
    la_d        = la_q;
    emit        = 1'b0;
    cmd_o.kind   = KIND_READ;
    cmd_o.base   = ent_base;
    cmd_o.offset = '0;
    case (level_q)
      LVL_1, LVL_2, LVL_3, LVL_4: begin
        if (op_i == OP_ENTRY) begin
          emit = 1'b1;
          if (!present) begin
            level_d      = LVL_IDLE;
            cmd_o.kind   = KIND_FAULT;
            cmd_o.base   = '0;
          end else begin
            case (level_q)
              LVL_1: begin
                level_d      = LVL_2;
                cmd_o.offset = idx_off2;
              end
              LVL_2: begin
                if (large_page) begin
                  level_d      = LVL_IDLE;
                  cmd_o.kind   = KIND_DONE;
                  cmd_o.base   = gib_base;
                  cmd_o.offset = la_q[OFF_W-1:0];
                end else begin
                  level_d      = LVL_3;
                  cmd_o.offset = idx_off3;
                end
              end
              LVL_3: begin
                if (large_page) begin
                  level_d      = LVL_IDLE;
                  cmd_o.kind   = KIND_DONE;
                  cmd_o.offset = OFF_W'(la_q[MIB_OFF_W-1:0]);
                end else begin
                  level_d      = LVL_4;
                  cmd_o.offset = idx_off4;
                end
              end
              default: begin
                level_d      = LVL_IDLE;
                cmd_o.kind   = KIND_DONE;
                cmd_o.offset = OFF_W'(la_q[PAGE_SHIFT-1:0]);
              end
            endcase
          end
        end
      end
      default: begin
        if (op_i == OP_TRANSLATE) begin
          emit         = 1'b1;
          level_d      = LVL_1;
          la_d         = linear_address_i;
          cmd_o.base   = root_base;
          cmd_o.offset = root_off;
        end
      end
    endcase
  end

  assign push_o = accept && emit;

  // Advance walk state on accepted transactions only
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= LVL_IDLE;
      la_q    <= '0;
    end else if (accept) begin
      level_q <= level_d;
      la_q    <= la_d;
    end
  end

  a_fault_idles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && cmd_o.kind == KIND_FAULT |=> level_q == LVL_IDLE)
    else $error("fault did not return walker to idle");

  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && cmd_o.kind == KIND_READ |=> level_q != LVL_IDLE)
    else $error("entry read issued but walker idle");

  a_idle_entry_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && level_q == LVL_IDLE && op_i == OP_ENTRY |-> !push_o)
    else $error("entry while idle produced a result");

endmodule

// File: rtl/ptw_queue.sv
// Short command queue between the walk front end and the address back end.
// Depends on ptw_pkg for cmd_t and the queue depth.
module ptw_queue import ptw_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  cmd_t  cmd_i,
  output logic  ready_o,
  output logic  valid_o,
  output cmd_t  cmd_o,
  input  logic  pop_i
);

  cmd_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              do_push, do_pop;

  assign ready_o = count_q != QCNT_W'(QDEPTH);
  assign valid_o = count_q != '0;
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  // Store commands
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QDEPTH))
    else $error("command queue overfilled");

endmodule

// File: rtl/ptw_back.sv
// Address back end: adds base and offset of each command and holds the
// result in the output register until the receiver takes it.
// Depends on ptw_pkg.
module ptw_back import ptw_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  cmd_t               cmd_i,
  output logic               pop_o,
  output logic               valid_o,
  input  logic               ready_i,
  output logic [KIND_W-1:0]  kind_o,
  output logic [ADDR_W-1:0]  address_o
);

  logic              out_valid_q;
  logic [KIND_W-1:0] kind_q;
  logic [ADDR_W-1:0] addr_q, addr_d;

  assign pop_o     = q_valid_i && (!out_valid_q || ready_i);
  assign addr_d    = cmd_i.base + ADDR_W'(cmd_i.offset);
  assign valid_o   = out_valid_q;
  assign kind_o    = kind_q;
  assign address_o = addr_q;

  // Hold valid until the transaction is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Load result payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      kind_q <= cmd_i.kind;
      addr_q <= addr_d;
    end
  end

endmodule

// File: rtl/four_level_page_table_walker.sv
// Four-level page table walker with an external memory port.
// Input channel req_i carries one transaction per item: op 0 is a translate
// request (table_root, linear_address), op 1 is a page table entry returned
// from memory (entry_word). Output channel rsp_o carries one transaction per
// result: kind 0 asks for an entry read at address, kind 1 gives the physical
// address of a finished walk, kind 2 reports a not-present fault.
// A translate request while a walk is active, and an entry while idle, are
// taken and dropped without a result.
// Each result is written into the command queue, then into the output register
// that drives rsp_o. Throughput: one transaction per cycle while the queue has
// room; the front end classifies in the accept cycle, a two-entry command queue
// decouples it from the back end, whose 52-bit add feeds the output register.
// When the receiver stalls, the output register holds and the queue fills;
// req_i.ready drops only when the queue is full.
// Reset (rst_ni low, asynchronous) returns the walker to idle and empties
// the queue and output register.
// Depends on ptw_pkg, ptw_if, ptw_front, ptw_queue and ptw_back.
module four_level_page_table_walker import ptw_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  ptw_req_if.sink    req_i,
  ptw_rsp_if.source  rsp_o
);

  logic push;
  cmd_t push_cmd;
  logic q_ready;
  logic q_valid;
  cmd_t q_cmd;
  logic pop;

  // Classify and walk
  ptw_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (req_i.valid),
    .ready_o          (req_i.ready),
    .op_i             (req_i.op),
    .table_root_i     (req_i.table_root),
    .linear_address_i (req_i.linear_address),
    .entry_word_i     (req_i.entry_word),
    .push_o           (push),
    .cmd_o            (push_cmd),
    .q_ready_i        (q_ready)
  );

  // Decouple front and back
  ptw_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .cmd_o   (q_cmd),
    .pop_i   (pop)
  );

  // Form addresses and drive the output channel
  ptw_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .cmd_i     (q_cmd),
    .pop_o     (pop),
    .valid_o   (rsp_o.valid),
    .ready_i   (rsp_o.ready),
    .kind_o    (rsp_o.kind),
    .address_o (rsp_o.address)
  );

endmodule

// File: bench/four_level_page_table_walker_test.sv
// Self-checking testbench for four_level_page_table_walker: drives translate
// requests and returned entries, predicts every read, done and fault result.
// Depends on ptw_pkg, the ptw_req_if/ptw_rsp_if interfaces and the walker RTL.
module four_level_page_table_walker_test import ptw_pkg::*;;

  // Walk levels of the predictor
  localparam logic [2:0] LVL_IDLE    = 3'd0;
  localparam logic [2:0] LVL_TOP     = 3'd1;
  localparam logic [2:0] LVL_DIR_PTR = 3'd2;
  localparam logic [2:0] LVL_DIR     = 3'd3;
  localparam logic [2:0] LVL_LEAF    = 3'd4;

  // Entry and root masks
  localparam logic [ADDR_W-1:0] TABLE_BASE_MASK =
    ((52'd1 << PHYS_BITS) - 52'd1) & ~52'hfff;
  localparam logic [ADDR_W-1:0] GIB_FRAME_MASK =
    {{(ADDR_W-GIB_SHIFT){1'b1}}, {GIB_SHIFT{1'b0}}};
  localparam logic [ROOT_W-1:0] ROOT_KEEP = {{(ROOT_W-4){1'b1}}, 4'h0};

  localparam int RANDOM_TARGET  = 1320;
  localparam int CALM_FROM      = 1100;
  localparam int HOLD_FROM      = 400;
  localparam int HOLD_CYCLES    = 250;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SHOWN_ERRORS   = 10;

  typedef struct packed {
    kind_e             kind;
    logic [ADDR_W-1:0] address;
  } walk_result_t;

  // Track the walk state and the results it must produce
  class walk_tracker;
    logic [2:0]      level;
    logic [LA_W-1:0] held_la;
    walk_result_t    pending[$];
    int errors, walks, reads, translations, faults;

    function new();
      level = LVL_IDLE;
      held_la = '0;
    endfunction

    function bit walking();
      return level != LVL_IDLE;
    endfunction

    function logic [ADDR_W-1:0] slot_offset(logic [LA_W-1:0] la, int pos);
      logic [IDX_W-1:0] idx;
      idx = la[pos +: IDX_W];
      return {{(ADDR_W-IDX_W-3){1'b0}}, idx, 3'b000};
    endfunction

    // Advance the walk for one accepted transaction; return 1 if a result is due
    function bit note_item(logic [OP_W-1:0] op, logic [ROOT_W-1:0] root,
                           logic [LA_W-1:0] la, logic [ENTRY_W-1:0] entry);
      logic [ADDR_W-1:0] base, offs, addr;
      walk_result_t      res;
      kind_e             kind;
      base = entry[ADDR_W-1:0] & TABLE_BASE_MASK;
      kind = KIND_READ;
      addr = '0;
      if (level == LVL_IDLE || level > LVL_LEAF) begin
        if (op != OP_TRANSLATE) return 1'b0;
        held_la = la;
        level = LVL_TOP;
        walks++;
        addr = {{(ADDR_W-ROOT_W){1'b0}}, root & ROOT_KEEP} + slot_offset(la, IDX1_POS);
      end else if (op != OP_ENTRY) begin
        return 1'b0;
      end else if (!entry[PRESENT_POS]) begin
        level = LVL_IDLE;
        kind = KIND_FAULT;
      end else begin
        case (level)
          LVL_TOP: begin
            level = LVL_DIR_PTR;
            addr = base + slot_offset(held_la, IDX2_POS);
          end
          LVL_DIR_PTR: begin
            if (entry[LARGE_POS]) begin
              level = LVL_IDLE;
              kind = KIND_DONE;
              offs = '0;
              offs[GIB_SHIFT-1:0] = held_la[GIB_SHIFT-1:0];
              addr = (entry[ADDR_W-1:0] & GIB_FRAME_MASK) + offs;
            end else begin
              level = LVL_DIR;
              addr = base + slot_offset(held_la, IDX3_POS);
            end
          end
          LVL_DIR: begin
            if (entry[LARGE_POS]) begin
              level = LVL_IDLE;
              kind = KIND_DONE;
              offs = '0;
              offs[MIB_OFF_W-1:0] = held_la[MIB_OFF_W-1:0];
              addr = base + offs;
            end else begin
              level = LVL_LEAF;
              addr = base + slot_offset(held_la, IDX4_POS);
            end
          end
          default: begin
            level = LVL_IDLE;
            kind = KIND_DONE;
            offs = '0;
            offs[PAGE_SHIFT-1:0] = held_la[PAGE_SHIFT-1:0];
            addr = base + offs;
          end
        endcase
      end
      case (kind)
        KIND_READ: reads++;
        KIND_DONE: translations++;
        default:   faults++;
      endcase
      res.kind = kind;
      res.address = addr;
      pending.push_back(res);
      return 1'b1;
    endfunction

    // Compare one result transaction with the oldest expectation
    function void check_result(logic [KIND_W-1:0] kind, logic [ADDR_W-1:0] address);
      walk_result_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= SHOWN_ERRORS)
          $display("ERROR: unexpected result kind=%0d address=%h", kind, address);
        return;
      end
      want = pending.pop_front();
      if (kind !== want.kind || address !== want.address) begin
        errors++;
        if (errors <= SHOWN_ERRORS)
          $display("ERROR: expected kind=%0d address=%h, got kind=%0d address=%h",
                   want.kind, want.address, kind, address);
      end
    endfunction

    // Count results that never arrived
    function void flag_leftovers();
      if (pending.size() != 0) begin
        errors += pending.size();
        $display("ERROR: %0d expected results never arrived", pending.size());
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  ptw_req_if req_ch();
  ptw_rsp_if rsp_ch();

  four_level_page_table_walker u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  walk_tracker sb = new();
  int  useful_items = 0;
  bit  calm = 1'b0;
  bit  holding_off = 1'b0;
  bit  hold_done = 1'b0;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [ENTRY_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [ROOT_W-1:0] rand_root();
    logic [ENTRY_W-1:0] r;
    r = rand64();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return r[ROOT_W-1:0];
    endcase
  endfunction

  function automatic logic [LA_W-1:0] rand_la();
    logic [ENTRY_W-1:0] r;
    r = rand64();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return r[LA_W-1:0];
    endcase
  endfunction

  function automatic logic [ENTRY_W-1:0] make_entry(bit present, bit large_page);
    logic [ENTRY_W-1:0] e;
    e = rand64();
    e[PRESENT_POS] = present;
    e[LARGE_POS] = large_page;
    return e;
  endfunction

  // Offer one transaction, after an optional idle burst, and hold it until taken
  task automatic send_item(input logic [OP_W-1:0] op, input logic [ROOT_W-1:0] root,
                           input logic [LA_W-1:0] la, input logic [ENTRY_W-1:0] entry);
    int gap;
    gap = 0;
    if (!calm && !holding_off && $urandom_range(0, 3) == 0)
      gap = $urandom_range(1, 15);
    repeat (gap) begin
      @(negedge clk_i);
      req_ch.valid <= 1'b0;
    end
    @(negedge clk_i);
    req_ch.valid          <= 1'b1;
    req_ch.op             <= op;
    req_ch.table_root     <= root;
    req_ch.linear_address <= la;
    req_ch.entry_word     <= entry;
    do @(posedge clk_i); while (!req_ch.ready);
    if (sb.note_item(op, root, la, entry)) useful_items++;
    if (useful_items >= CALM_FROM) calm = 1'b1;
  endtask

  // One well-formed walk with random content, with stray requests mixed in
  task automatic run_walk();
    send_item(OP_TRANSLATE, rand_root(), rand_la(), rand64());
    while (sb.walking()) begin
      case ($urandom_range(0, 19))
        0:       send_item(OP_TRANSLATE, rand_root(), rand_la(), rand64());
        1:       send_item(OP_ENTRY, rand_root(), rand_la(), '1);
        default: send_item(OP_ENTRY, rand_root(), rand_la(),
                           make_entry($urandom_range(0, 9) != 0,
                                      $urandom_range(0, 3) == 0));
      endcase
    end
  endtask

  // Directed walks: every level kind, every fault level, extremes, ignored items
  task automatic run_directed();
    send_item(OP_ENTRY, '1, '1, '1);
    // 1 GiB page at the top of the ranges, with a request while busy
    send_item(OP_TRANSLATE, '1, '1, '0);
    send_item(OP_TRANSLATE, '0, '0, '1);
    send_item(OP_ENTRY, '0, '0, '1);
    send_item(OP_ENTRY, '0, '0, '1);
    // zero root and address; large bit at the top is ignored; leaf absent
    send_item(OP_TRANSLATE, '0, '0, '0);
    send_item(OP_ENTRY, '0, '0, make_entry(1'b1, 1'b1));
    send_item(OP_ENTRY, '0, '0, make_entry(1'b1, 1'b0));
    send_item(OP_ENTRY, '0, '0, make_entry(1'b1, 1'b0));
    send_item(OP_ENTRY, '0, '0, make_entry(1'b0, 1'b1));
    // 2 MiB page
    send_item(OP_TRANSLATE, rand_root(), rand_la(), rand64());
    send_item(OP_ENTRY, '0, '0, make_entry(1'b1, 1'b0));
    send_item(OP_ENTRY, '0, '0, make_entry(1'b1, 1'b0));
    send_item(OP_ENTRY, '0, '0, '1);
    // 4 KiB page, leaf large bit ignored
    send_item(OP_TRANSLATE, rand_root(), rand_la(), rand64());
    send_item(OP_ENTRY, '0, '0, make_entry(1'b1, 1'b0));
    send_item(OP_ENTRY, '0, '0, make_entry(1'b1, 1'b0));
    send_item(OP_ENTRY, '0, '0, make_entry(1'b1, 1'b0));
    send_item(OP_ENTRY, '0, '0, '1);
    // absent entries at the upper three levels
    send_item(OP_TRANSLATE, rand_root(), rand_la(), rand64());
    send_item(OP_ENTRY, '1, '1, '0);
    send_item(OP_TRANSLATE, rand_root(), rand_la(), rand64());
    send_item(OP_ENTRY, '0, '0, make_entry(1'b1, 1'b0));
    send_item(OP_ENTRY, '0, '0, make_entry(1'b0, 1'b1));
    send_item(OP_TRANSLATE, rand_root(), rand_la(), rand64());
    send_item(OP_ENTRY, '0, '0, make_entry(1'b1, 1'b0));
    send_item(OP_ENTRY, '0, '0, make_entry(1'b1, 1'b0));
    send_item(OP_ENTRY, '0, '0, make_entry(1'b0, 1'b1));
  endtask

  // Result side: random stall bursts plus one long hold-off to fill the block
  initial begin
    int stall_left;
    bit rdy;
    stall_left = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!hold_done && useful_items >= HOLD_FROM) begin
        hold_done = 1'b1;
        holding_off = 1'b1;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 15) - 1;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
        holding_off = 1'b0;
      end
      rsp_ch.ready <= rdy;
    end
  end

  // Check each result transaction
  always @(posedge clk_i) begin
    if (rst_ni && rsp_ch.valid && rsp_ch.ready)
      sb.check_result(rsp_ch.kind, rsp_ch.address);
  end

  // Stop the run when neither channel moves for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("ERROR: no transaction for %0d cycles", WATCHDOG_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  // Main sequence
  initial begin
    rst_ni = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.op = OP_TRANSLATE;
    req_ch.table_root = '0;
    req_ch.linear_address = '0;
    req_ch.entry_word = '0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    run_directed();
    while (useful_items < RANDOM_TARGET) begin
      if ($urandom_range(0, 99) < 85)
        run_walk();
      else
        send_item($urandom_range(0, 1) ? OP_ENTRY : OP_TRANSLATE,
                  rand_root(), rand_la(), rand64());
    end
    @(negedge clk_i);
    req_ch.valid <= 1'b0;

    // Drain, then let the pipeline settle
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    sb.flag_leftovers();

    $display("Covered %0d walks: %0d entry reads, %0d translations, %0d faults.",
             sb.walks, sb.reads, sb.translations, sb.faults);
    $display("Mismatches and stray results: %0d", sb.errors);
    if (sb.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
